// ===== rtl/core/sed_pkg.sv =====
// Package for the string escape decoder.
// Holds the character constants, the decode state types and the result payload type.
// No dependencies; compile first.
package sed_pkg;

   localparam int CHAR_W  = 21;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 3;

   // Code points that steer the decoder
   localparam logic [CHAR_W-1:0] CH_BSLASH  = 21'h00005C;
   localparam logic [CHAR_W-1:0] CH_QUOTE   = 21'h000022;
   localparam logic [CHAR_W-1:0] CH_LOWER_T = 21'h000074;
   localparam logic [CHAR_W-1:0] CH_LOWER_N = 21'h00006E;
   localparam logic [CHAR_W-1:0] CH_LOWER_R = 21'h000072;
   localparam logic [CHAR_W-1:0] CH_LOWER_U = 21'h000075;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 21'h000061;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 21'h000041;

   // Decoded control characters
   localparam logic [DATA_W-1:0] CODE_TAB = 32'd9;
   localparam logic [DATA_W-1:0] CODE_LF  = 32'd10;
   localparam logic [DATA_W-1:0] CODE_CR  = 32'd13;

   // Offsets that turn a code point into a hex digit value
   localparam logic [DATA_W-1:0] LOWER_OFFSET = 32'h00000057;   // 'a' - 10
   localparam logic [DATA_W-1:0] UPPER_OFFSET = 32'h00000037;   // 'A' - 10
   localparam logic [DATA_W-1:0] DIGIT_OFFSET = 32'h00000030;   // '0'

   // Hex digit counts of the short and long escapes
   localparam logic [COUNT_W-1:0] SHORT_HEX = 3'd4;
   localparam logic [COUNT_W-1:0] LONG_HEX  = 3'd6;

   typedef enum logic [2:0] {
      MODE_PLAIN  = 3'b001,
      MODE_ESCAPE = 3'b010,
      MODE_HEX    = 3'b100
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [COUNT_W-1:0]  digits_left;
      logic [DATA_W-1:0]   hex_accum;
   } dec_state_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_char;
      logic              char_present;
      logic              out_last;
      logic              trunc_error;
   } rsp_payload_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } step_out_type;

endpackage

// ===== rtl/core/sed_if.sv =====
// Channel interfaces of the string escape decoder: code points in, decoded results out.
// Depends on sed_pkg.
interface sed_req_if import sed_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] in_char;
   logic              in_last;

   modport source (output valid, in_char, in_last, input ready);
   modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface sed_rsp_if import sed_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_char;
   logic              char_present;
   logic              out_last;
   logic              trunc_error;

   modport source (output valid, out_char, char_present, out_last, trunc_error, input ready);
   modport sink   (input valid, out_char, char_present, out_last, trunc_error, output ready);
endinterface

// ===== rtl/core/sed_step.sv =====
// Next-state and result logic for one code point of the escape decoder.
// Purely combinational; depends on sed_pkg.
module sed_step import sed_pkg::*; (
   input  dec_state_type     state_cur,
   input  logic [CHAR_W-1:0] in_char,
   input  logic              in_last,
   output dec_state_type     state_nxt,
   output step_out_type      step_out
);

   logic [DATA_W-1:0]  char_ext;
   logic [DATA_W-1:0]  digit;
   logic [COUNT_W-1:0] digits_dec;
   logic               have;
   logic [DATA_W-1:0]  value;
   dec_state_type      state_mid;

   assign char_ext = {{(DATA_W-CHAR_W){1'b0}}, in_char};

   // Unchecked hex conversion; wraps below '0'
   always_comb begin
      priority if (in_char >= CH_LOWER_A) begin
         digit = char_ext - LOWER_OFFSET;
      end else if (in_char >= CH_UPPER_A) begin
         digit = char_ext - UPPER_OFFSET;
      end else begin
         digit = char_ext - DIGIT_OFFSET;
      end
   end

   assign digits_dec = (state_cur.digits_left != '0) ?
                       state_cur.digits_left - 3'd1 : state_cur.digits_left;

   always_comb begin
      state_mid = state_cur;
      have      = 1'b0;
      value     = '0;
      unique case (state_cur.mode)
         MODE_PLAIN: begin
            if (in_char == CH_BSLASH) begin
               state_mid.mode = MODE_ESCAPE;
            end else begin
               have  = 1'b1;
               value = char_ext;
            end
         end
         MODE_ESCAPE: begin
            priority if (in_char == CH_LOWER_T) begin
               have = 1'b1; value = CODE_TAB; state_mid.mode = MODE_PLAIN;
            end else if (in_char == CH_LOWER_N) begin
               have = 1'b1; value = CODE_LF;  state_mid.mode = MODE_PLAIN;
            end else if (in_char == CH_LOWER_R) begin
               have = 1'b1; value = CODE_CR;  state_mid.mode = MODE_PLAIN;
            end else if (in_char == CH_QUOTE || in_char == CH_BSLASH) begin
               have = 1'b1; value = char_ext; state_mid.mode = MODE_PLAIN;
            end else begin
               state_mid.mode        = MODE_HEX;
               state_mid.digits_left = (in_char == CH_LOWER_U) ? SHORT_HEX : LONG_HEX;
               state_mid.hex_accum   = '0;
            end
         end
         MODE_HEX: begin
            // Shift in one digit, wrap mod 2^32
            state_mid.hex_accum   = {state_cur.hex_accum[DATA_W-5:0], 4'b0000} + digit;
            state_mid.digits_left = digits_dec;
            if (digits_dec == '0) begin
               have           = 1'b1;
               value          = state_mid.hex_accum;
               state_mid.mode = MODE_PLAIN;
            end
         end
         default: begin
            state_mid.mode = MODE_PLAIN;
         end
      endcase
   end

   always_comb begin
      step_out.emit                 = have || in_last;
      step_out.payload.out_char     = have ? value : '0;
      step_out.payload.char_present = have;
      step_out.payload.out_last     = in_last;
      step_out.payload.trunc_error  = in_last && !have && (state_mid.mode != MODE_PLAIN);
      if (in_last) begin
         // The string is closed: start the next one clean
         state_nxt.mode        = MODE_PLAIN;
         state_nxt.digits_left = '0;
         state_nxt.hex_accum   = '0;
      end else begin
         state_nxt = state_mid;
      end
   end

endmodule

// ===== rtl/core/string_escape_decoder.sv =====
// String escape decoder, top level. Depends on sed_pkg, sed_if (channel interfaces)
// and sed_step (per-character decode logic).
//
// Takes the content code points of a quoted string, one per transfer on req_chan, with
// in_last marking the final one, and returns decoded characters on rsp_chan. A backslash
// opens an escape: t, n, r give TAB, LF, CR; a quote or backslash stands for itself; 'u'
// reads the next 4 code points as hex digits and any other character reads 6. Hex digits
// are not checked; the value wraps modulo 2^32. Characters that only advance an escape
// produce no transfer. The closing code point always produces exactly one transfer with
// out_last set; if the string ended inside an escape that transfer carries trunc_error
// with char_present clear and out_char zero. Throughput is one code point per cycle while
// rsp_chan is not stalled: the decode state loop is a single 32-bit shift-add plus a few
// compares, so a new code point can follow every cycle. A result passes through the input
// register, then the result register. A stalled result holds in the result register while
// one more code point waits in the input register; code points that produce no result keep
// moving during the stall.
module string_escape_decoder import sed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sed_req_if.sink       req_chan,
   sed_rsp_if.source     rsp_chan
);

   // Input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // Decode state
   dec_state_type state_ff;
   dec_state_type state_in;

   // Result register
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_payload_ff;

   step_out_type step_out;
   logic         req_take;
   logic         stage_adv;
   logic         out_free;

   sed_step u_step (
      .state_cur (state_ff),
      .in_char   (in_char_ff),
      .in_last   (in_last_ff),
      .state_nxt (state_in),
      .step_out  (step_out)
   );

   // Result register can take a new value when empty or drained this cycle
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   // Advance the input register when its result has a place or it has no result
   assign stage_adv = in_valid_ff && (!step_out.emit || out_free);

   assign req_chan.ready = !in_valid_ff || stage_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (stage_adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (stage_adv && step_out.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         state_ff.mode         <= MODE_PLAIN;
         state_ff.digits_left  <= '0;
         state_ff.hex_accum    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (stage_adv) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload: capture the code point on an input transfer, the result when it is made
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.in_char;
         in_last_ff <= req_chan.in_last;
      end
      if (stage_adv && step_out.emit) begin
         out_payload_ff <= step_out.payload;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_char     = out_payload_ff.out_char;
   assign rsp_chan.char_present = out_payload_ff.char_present;
   assign rsp_chan.out_last     = out_payload_ff.out_last;
   assign rsp_chan.trunc_error  = out_payload_ff.trunc_error;

endmodule

// ===== rtl/core/sed_checker.sv =====
// Port-level checker for the string escape decoder, with its bind to the top level.
// Depends on sed_pkg and on the top level's channel ports.
module sed_checker import sed_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_out_char,
   input logic              rsp_char_present,
   input logic              rsp_out_last,
   input logic              rsp_trunc_error
);

   // Hold a stalled result
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_char) && $stable(rsp_char_present)
         && $stable(rsp_out_last) && $stable(rsp_trunc_error))
      else $error("stalled result changed");

   // A transfer without a character only closes a string
   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_present |-> rsp_out_last && rsp_out_char == '0)
      else $error("empty result not closing a string");

   // Truncation is flagged only on a closing transfer with no character
   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trunc_error |-> rsp_out_last && !rsp_char_present)
      else $error("malformed truncation result");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_char     (rsp_chan.out_char),
   .rsp_char_present (rsp_chan.char_present),
   .rsp_out_last     (rsp_chan.out_last),
   .rsp_trunc_error  (rsp_chan.trunc_error)
);
